/* hw/rtl/mrw_pkg.sv */
// ----------------------------------------------------------------------------
// Miller-Rabin witness test package
// Shared widths, verdict codes and sequencer states.
// ----------------------------------------------------------------------------
package mrw_pkg;

  localparam int NUM_BITS = 32;
  localparam int CNT_W    = $clog2(NUM_BITS + 1);

  typedef logic [NUM_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    VERDICT_COMPOSITE = 2'd0,
    VERDICT_PROBABLE  = 2'd1,
    VERDICT_SMALL     = 2'd2
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SPLIT,
    ST_POW_MUL,
    ST_POW_MUL_WAIT,
    ST_POW_SQR,
    ST_POW_SQR_WAIT,
    ST_CHECK,
    ST_SQR,
    ST_SQR_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

/* hw/rtl/mrw_modmul.sv */
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a*b mod m by interleaved shift-add, one bit of b per cycle.
// Operands must already be below m.
// ----------------------------------------------------------------------------
module mrw_modmul (
  input  logic             clk,
  input  logic             rst,
  input  mrw_pkg::mul_ctl_t ctl,
  input  mrw_pkg::word_t   a,
  input  mrw_pkg::word_t   b,
  input  mrw_pkg::word_t   m,
  output mrw_pkg::mul_sts_t sts,
  output mrw_pkg::word_t   product
);

  mrw_pkg::word_t acc;
  mrw_pkg::word_t op_a;
  mrw_pkg::word_t op_b;
  mrw_pkg::word_t modulus;
  mrw_pkg::cnt_t  count;
  logic           running;
  logic           done;

  logic [mrw_pkg::NUM_BITS:0]   dbl;
  logic [mrw_pkg::NUM_BITS:0]   dbl_red;
  logic [mrw_pkg::NUM_BITS+1:0] sum;
  logic [mrw_pkg::NUM_BITS+1:0] sum_red;
  mrw_pkg::word_t               acc_next;

  always_comb begin
    // double, reduce once, add the next bit's addend, reduce once
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    sum     = {1'b0, dbl_red} +
              (op_b[mrw_pkg::NUM_BITS-1] ? {2'b00, op_a} : '0);
    sum_red = (sum >= {2'b00, modulus}) ? sum - {2'b00, modulus} : sum;
    acc_next = sum_red[mrw_pkg::NUM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !running) begin
        running <= 1'b1;
        count   <= mrw_pkg::cnt_t'(mrw_pkg::NUM_BITS);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == mrw_pkg::cnt_t'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !running) begin
      acc     <= '0;
      op_a    <= a;
      op_b    <= b;
      modulus <= m;
    end else if (running) begin
      acc  <= acc_next;
      op_b <= {op_b[mrw_pkg::NUM_BITS-2:0], 1'b0};
    end
  end

  assign sts.busy = running;
  assign sts.done = done;
  assign product  = acc;

endmodule

/* hw/rtl/mrw_reduce.sv */
// ----------------------------------------------------------------------------
// Bit-serial reducer
// Computes x mod m by restoring shift-subtract, one bit of x per cycle.
// ----------------------------------------------------------------------------
module mrw_reduce (
  input  logic             clk,
  input  logic             rst,
  input  mrw_pkg::mul_ctl_t ctl,
  input  mrw_pkg::word_t   x,
  input  mrw_pkg::word_t   m,
  output mrw_pkg::mul_sts_t sts,
  output mrw_pkg::word_t   rem
);

  mrw_pkg::word_t r;
  mrw_pkg::word_t dividend;
  mrw_pkg::word_t modulus;
  mrw_pkg::cnt_t  count;
  logic           running;
  logic           done;

  logic [mrw_pkg::NUM_BITS:0] trial;

  assign trial = {r, dividend[mrw_pkg::NUM_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !running) begin
        running <= 1'b1;
        count   <= mrw_pkg::cnt_t'(mrw_pkg::NUM_BITS);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == mrw_pkg::cnt_t'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !running) begin
      r        <= '0;
      dividend <= x;
      modulus  <= m;
    end else if (running) begin
      dividend <= {dividend[mrw_pkg::NUM_BITS-2:0], 1'b0};
      if (trial >= {1'b0, modulus}) begin
        r <= mrw_pkg::word_t'(trial - {1'b0, modulus});
      end else begin
        r <= trial[mrw_pkg::NUM_BITS-1:0];
      end
    end
  end

  assign sts.busy = running;
  assign sts.done = done;
  assign rem      = r;

endmodule

/* hw/rtl/miller_rabin_witness_test_unit.sv */
// ----------------------------------------------------------------------------
// Miller-Rabin witness test unit
// Sequence: small or even candidates strobe the verdict in the cycle after the
//   request. Odd candidates first reduce the base with the reducer, strip the
//   trailing zeros of n-1 to split it, then run modular multiplies on the
//   bit-serial multiplier: one squaring per exponent bit, one multiply per set
//   bit, then up to r-1 squarings.
// Throughput: one request at a time; busy stays high until verdict strobes.
// Reset: synchronous rst returns the sequencer to idle and drops busy.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [31:0]    candidate,
  input  logic [31:0]    witness,
  output logic           done,
  output logic [1:0]     verdict
);

  mrw_pkg::state_t state;
  mrw_pkg::state_t state_next;

  mrw_pkg::word_t n;
  mrw_pkg::word_t nm1;
  mrw_pkg::word_t d;
  mrw_pkg::word_t x;
  mrw_pkg::word_t base;
  mrw_pkg::cnt_t  r;
  mrw_pkg::verdict_t result;

  mrw_pkg::mul_ctl_t mul_ctl;
  mrw_pkg::mul_ctl_t red_ctl;
  mrw_pkg::mul_sts_t mul_sts;
  mrw_pkg::mul_sts_t red_sts;
  mrw_pkg::word_t    mul_a;
  mrw_pkg::word_t    mul_b;
  mrw_pkg::word_t    product;
  mrw_pkg::word_t    rem;

  mrw_pkg::word_t cand_w;
  mrw_pkg::word_t wit_w;
  logic           small_case;
  mrw_pkg::verdict_t small_verdict;

  assign cand_w = candidate[mrw_pkg::NUM_BITS-1:0];
  assign wit_w  = witness[mrw_pkg::NUM_BITS-1:0];

  always_comb begin
    small_case    = 1'b1;
    small_verdict = mrw_pkg::VERDICT_COMPOSITE;
    if (cand_w == mrw_pkg::word_t'(2) || cand_w == mrw_pkg::word_t'(3)) begin
      small_verdict = mrw_pkg::VERDICT_SMALL;
    end else if (cand_w <= mrw_pkg::word_t'(4) || !cand_w[0]) begin
      small_verdict = mrw_pkg::VERDICT_COMPOSITE;
    end else begin
      small_case = 1'b0;
    end
  end

  mrw_modmul u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mul_ctl),
    .a       (mul_a),
    .b       (mul_b),
    .m       (n),
    .sts     (mul_sts),
    .product (product)
  );

  // reducer loads its operands straight from the request ports
  mrw_reduce u_red (
    .clk (clk),
    .rst (rst),
    .ctl (red_ctl),
    .x   (wit_w),
    .m   (cand_w),
    .sts (red_sts),
    .rem (rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mrw_pkg::ST_IDLE: begin
        if (start) begin
          state_next = small_case ? mrw_pkg::ST_DONE : mrw_pkg::ST_REDUCE;
        end
      end
      mrw_pkg::ST_REDUCE: begin
        if (red_sts.done) state_next = mrw_pkg::ST_SPLIT;
      end
      mrw_pkg::ST_SPLIT: begin
        if (d[0]) state_next = mrw_pkg::ST_POW_MUL;
      end
      mrw_pkg::ST_POW_MUL: begin
        if (d == '0) state_next = mrw_pkg::ST_CHECK;
        else if (d[0]) state_next = mrw_pkg::ST_POW_MUL_WAIT;
        else state_next = mrw_pkg::ST_POW_SQR;
      end
      mrw_pkg::ST_POW_MUL_WAIT: begin
        if (mul_sts.done) state_next = mrw_pkg::ST_POW_SQR;
      end
      mrw_pkg::ST_POW_SQR: begin
        state_next = mrw_pkg::ST_POW_SQR_WAIT;
      end
      mrw_pkg::ST_POW_SQR_WAIT: begin
        if (mul_sts.done) state_next = mrw_pkg::ST_POW_MUL;
      end
      mrw_pkg::ST_CHECK: begin
        if (x == mrw_pkg::word_t'(1) || x == nm1) state_next = mrw_pkg::ST_DONE;
        else if (r <= mrw_pkg::cnt_t'(1)) state_next = mrw_pkg::ST_DONE;
        else state_next = mrw_pkg::ST_SQR;
      end
      mrw_pkg::ST_SQR: begin
        state_next = mrw_pkg::ST_SQR_WAIT;
      end
      mrw_pkg::ST_SQR_WAIT: begin
        if (mul_sts.done) begin
          if (product == mrw_pkg::word_t'(1) || product == nm1) begin
            state_next = mrw_pkg::ST_DONE;
          end else if (r <= mrw_pkg::cnt_t'(2)) begin
            state_next = mrw_pkg::ST_DONE;
          end else begin
            state_next = mrw_pkg::ST_SQR;
          end
        end
      end
      mrw_pkg::ST_DONE: begin
        state_next = mrw_pkg::ST_IDLE;
      end
      default: state_next = mrw_pkg::ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    mul_ctl.start = 1'b0;
    red_ctl.start = 1'b0;
    mul_a         = x;
    mul_b         = base;
    case (state)
      mrw_pkg::ST_IDLE: begin
        red_ctl.start = start && !small_case;
      end
      mrw_pkg::ST_POW_MUL: begin
        mul_ctl.start = (d != '0) && d[0];
      end
      mrw_pkg::ST_POW_SQR: begin
        mul_ctl.start = 1'b1;
        mul_a         = base;
      end
      mrw_pkg::ST_SQR: begin
        mul_ctl.start = 1'b1;
        mul_b         = x;
      end
      default: begin
        mul_ctl.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mrw_pkg::ST_IDLE: begin
        if (start) begin
          n      <= cand_w;
          nm1    <= cand_w - 1'b1;
          d      <= cand_w - 1'b1;
          r      <= '0;
          result <= small_verdict;
        end
      end
      mrw_pkg::ST_REDUCE: begin
        base <= rem;
        x    <= mrw_pkg::word_t'(1);
      end
      mrw_pkg::ST_SPLIT: begin
        // drop one trailing zero per cycle
        if (!d[0]) begin
          d <= d >> 1;
          r <= r + 1'b1;
        end
      end
      mrw_pkg::ST_POW_MUL_WAIT: begin
        if (mul_sts.done) x <= product;
      end
      mrw_pkg::ST_POW_SQR: begin
        d <= d >> 1;
      end
      mrw_pkg::ST_POW_SQR_WAIT: begin
        if (mul_sts.done) base <= product;
      end
      mrw_pkg::ST_CHECK: begin
        if (x == mrw_pkg::word_t'(1) || x == nm1) result <= mrw_pkg::VERDICT_PROBABLE;
        else result <= mrw_pkg::VERDICT_COMPOSITE;
      end
      mrw_pkg::ST_SQR_WAIT: begin
        if (mul_sts.done) begin
          x <= product;
          r <= r - 1'b1;
          if (product == nm1) result <= mrw_pkg::VERDICT_PROBABLE;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy    = (state != mrw_pkg::ST_IDLE);
  assign done    = (state == mrw_pkg::ST_DONE);
  assign verdict = result;

endmodule

/* hw/rtl/mrw_checker.sv */
// ----------------------------------------------------------------------------
// Miller-Rabin witness test port checker
// Watches the top-level ports for handshake and verdict consistency.
// ----------------------------------------------------------------------------
module mrw_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [31:0] candidate,
  input logic       done,
  input logic [1:0] verdict
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but busy not raised");

  a_done_drops_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after verdict");

  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    done |-> verdict != 2'd3)
    else $error("verdict code out of range");

  a_small_prime: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (candidate == 32'd2 || candidate == 32'd3)
      |=> done && verdict == mrw_pkg::VERDICT_SMALL)
    else $error("small prime not reported");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("verdict strobe outside a request");

endmodule

bind miller_rabin_witness_test_unit mrw_checker u_mrw_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .candidate (candidate),
  .done      (done),
  .verdict   (verdict)
);
